[sv/bssi_pkg.sv]
// ----------------------------------------------------------------------------
// bssi_pkg
// Shared sizes, register indexes, result codes and the command and status
// bundles that join the controller to the datapath.
// ----------------------------------------------------------------------------
package bssi_pkg;

  // list geometry
  localparam int NUM_LAYERS        = 23;
  localparam int ENTRIES_PER_LAYER = 64;
  localparam int LAYER_SPAN        = 10000;

  // fixed field widths
  localparam int ID_W       = 18;
  localparam int LAYER_W    = 5;
  localparam int COUNT_W    = 7;
  localparam int POSITION_W = 6;
  localparam int STATUS_W   = 3;

  // internal widths that follow from the geometry
  localparam int LAY_W  = (NUM_LAYERS > 1) ? $clog2(NUM_LAYERS) : 1;
  localparam int OFF_W  = $clog2(ENTRIES_PER_LAYER);
  localparam int CNT_W  = $clog2(ENTRIES_PER_LAYER + 1);
  localparam int ADDR_W = $clog2(NUM_LAYERS * ENTRIES_PER_LAYER);
  localparam int MEM_DEPTH = NUM_LAYERS * ENTRIES_PER_LAYER;

  // register reset values
  localparam logic [ID_W-1:0] LOWEST_RESET  = 18'd50000;
  localparam logic [ID_W-1:0] HIGHEST_RESET = 18'd221479;

  // register indexes
  localparam logic CFG_LOWEST  = 1'b0;
  localparam logic CFG_HIGHEST = 1'b1;

  // result codes
  localparam logic [STATUS_W-1:0] ST_INSERTED   = 3'd0;
  localparam logic [STATUS_W-1:0] ST_PRESENT    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_OUT_RANGE  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL       = 3'd3;
  localparam logic [STATUS_W-1:0] ST_READ_OK    = 3'd4;
  localparam logic [STATUS_W-1:0] ST_READ_EMPTY = 3'd5;

  // commands from the controller
  typedef struct packed {
    logic                item_load;
    logic                decode;
    logic                lookup;
    logic                scan_start;
    logic                scan_step;
    logic                scan_end;
    logic                pos_clear;
    logic                shift_start;
    logic                shift_step;
    logic                write_new;
    logic                rd_issue;
    logic                val_load;
    logic                res_load;
    logic [STATUS_W-1:0] res_code;
    logic                res_blank;
  } cmd_t;

  // status back to the controller
  typedef struct packed {
    logic kind;
    logic lay_ok;
    logic cnt_zero;
    logic rd_ok;
    logic hit_ge;
    logic hit_eq;
    logic scan_last;
    logic dup;
    logic full;
    logic pos_at_end;
    logic shift_last;
  } st_t;

endpackage

[sv/bssi_ctrl.sv]
// ----------------------------------------------------------------------------
// bssi_ctrl
// Sequencer for one word at a time: decode, list scan, shift, final write,
// entry read and result hand-off. Holds the result valid flag.
// ----------------------------------------------------------------------------
module bssi_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            item_valid,
  output logic            item_stall,
  output logic            result_valid,
  input  logic            result_stall,
  input  bssi_pkg::st_t   st,
  output bssi_pkg::cmd_t  cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DECODE = 4'd1;
  localparam logic [3:0] S_LOOKUP = 4'd2;
  localparam logic [3:0] S_BRANCH = 4'd3;
  localparam logic [3:0] S_SCAN   = 4'd4;
  localparam logic [3:0] S_DECIDE = 4'd5;
  localparam logic [3:0] S_SHIFT  = 4'd6;
  localparam logic [3:0] S_WRITE  = 4'd7;
  localparam logic [3:0] S_RDWAIT = 4'd8;
  localparam logic [3:0] S_DONE   = 4'd9;

  logic [3:0]                    state, state_next;
  logic [bssi_pkg::STATUS_W-1:0] code, code_next;
  logic                          blank, blank_next;
  logic                          result_free;

  assign item_stall  = (state != S_IDLE);
  assign result_free = !result_valid || !result_stall;

  // next state and commands
  always_comb begin
    cmd        = '0;
    state_next = state;
    code_next  = code;
    blank_next = blank;
    unique case (state)
      S_IDLE: begin
        if (item_valid) begin
          cmd.item_load = 1'b1;
          state_next    = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.decode = 1'b1;
        state_next = S_LOOKUP;
      end
      S_LOOKUP: begin
        cmd.lookup = 1'b1;
        state_next = S_BRANCH;
      end
      S_BRANCH: begin
        if (!st.kind) begin
          if (!st.lay_ok) begin
            code_next  = bssi_pkg::ST_OUT_RANGE;
            blank_next = 1'b1;
            state_next = S_DONE;
          end else if (st.cnt_zero) begin
            cmd.pos_clear = 1'b1;
            state_next    = S_DECIDE;
          end else begin
            cmd.scan_start = 1'b1;
            state_next     = S_SCAN;
          end
        end else begin
          if (!st.lay_ok) begin
            code_next  = bssi_pkg::ST_READ_EMPTY;
            blank_next = 1'b1;
            state_next = S_DONE;
          end else if (st.rd_ok) begin
            cmd.rd_issue = 1'b1;
            state_next   = S_RDWAIT;
          end else begin
            code_next  = bssi_pkg::ST_READ_EMPTY;
            blank_next = 1'b0;
            state_next = S_DONE;
          end
        end
      end
      S_SCAN: begin
        if (st.hit_ge || st.scan_last) begin
          cmd.scan_end = 1'b1;
          state_next   = S_DECIDE;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_DECIDE: begin
        blank_next = 1'b0;
        if (st.dup) begin
          code_next  = bssi_pkg::ST_PRESENT;
          state_next = S_DONE;
        end else if (st.full) begin
          code_next  = bssi_pkg::ST_FULL;
          state_next = S_DONE;
        end else if (st.pos_at_end) begin
          state_next = S_WRITE;
        end else begin
          cmd.shift_start = 1'b1;
          state_next      = S_SHIFT;
        end
      end
      S_SHIFT: begin
        cmd.shift_step = 1'b1;
        if (st.shift_last) begin
          state_next = S_WRITE;
        end
      end
      S_WRITE: begin
        cmd.write_new = 1'b1;
        code_next     = bssi_pkg::ST_INSERTED;
        blank_next    = 1'b0;
        state_next    = S_DONE;
      end
      S_RDWAIT: begin
        cmd.val_load = 1'b1;
        code_next    = bssi_pkg::ST_READ_OK;
        blank_next   = 1'b0;
        state_next   = S_DONE;
      end
      S_DONE: begin
        if (result_free) begin
          cmd.res_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    cmd.res_code  = code;
    cmd.res_blank = blank;
  end

  // state and result flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      code         <= bssi_pkg::ST_INSERTED;
      blank        <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      code  <= code_next;
      blank <= blank_next;
      if (cmd.res_load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule

[sv/bssi_dp.sv]
// ----------------------------------------------------------------------------
// bssi_dp
// Datapath: range registers, item registers, layer decode, per-layer counts,
// the entry memory with its scan and shift address logic, and the result
// word registers.
// ----------------------------------------------------------------------------
module bssi_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic                                cfg_index,
  input  logic [bssi_pkg::ID_W-1:0]           cfg_data,
  input  logic                                kind,
  input  logic [bssi_pkg::ID_W-1:0]           module_id,
  input  logic [bssi_pkg::LAYER_W-1:0]        read_layer,
  input  logic [bssi_pkg::POSITION_W-1:0]     read_position,
  input  bssi_pkg::cmd_t                      cmd,
  output bssi_pkg::st_t                       st,
  output logic [bssi_pkg::STATUS_W-1:0]       status,
  output logic [bssi_pkg::LAYER_W-1:0]        layer,
  output logic [bssi_pkg::COUNT_W-1:0]        layer_count,
  output logic [bssi_pkg::ID_W-1:0]           entry_value
);

  logic [bssi_pkg::ID_W-1:0]       lowest_id, highest_id;

  logic                            item_kind;
  logic [bssi_pkg::ID_W-1:0]       item_id;
  logic [bssi_pkg::LAYER_W-1:0]    item_rlay;
  logic [bssi_pkg::POSITION_W-1:0] item_rpos;

  logic [bssi_pkg::LAY_W-1:0]      lay;
  logic                            lay_ok;
  logic [bssi_pkg::CNT_W-1:0]      cnt;
  logic [bssi_pkg::ADDR_W-1:0]     base;
  logic [bssi_pkg::OFF_W-1:0]      ppos;
  logic [bssi_pkg::CNT_W-1:0]      pos;
  logic                            dup;
  logic [bssi_pkg::OFF_W-1:0]      k;
  logic [bssi_pkg::ID_W-1:0]       val;

  logic [bssi_pkg::CNT_W-1:0]      counts [bssi_pkg::NUM_LAYERS];
  logic [bssi_pkg::ID_W-1:0]       mem [bssi_pkg::MEM_DEPTH];
  logic [bssi_pkg::ID_W-1:0]       rdata;

  logic [bssi_pkg::NUM_LAYERS-1:0] ge;
  logic [bssi_pkg::LAY_W-1:0]      lay_ins;
  logic                            range_ok;
  logic                            rlay_ok;

  logic [bssi_pkg::OFF_W-1:0]      roff, woff;
  logic [bssi_pkg::ADDR_W-1:0]     raddr, waddr;
  logic [bssi_pkg::ID_W-1:0]       wdata;
  logic                            mem_we;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      lowest_id  <= bssi_pkg::LOWEST_RESET;
      highest_id <= bssi_pkg::HIGHEST_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        bssi_pkg::CFG_LOWEST:  lowest_id  <= cfg_data;
        bssi_pkg::CFG_HIGHEST: highest_id <= cfg_data;
        default: ;
      endcase
    end
  end

  // layer of an identifier: thermometer of span boundaries, then its edge
  always_comb begin
    for (int j = 0; j < bssi_pkg::NUM_LAYERS; j++) begin
      ge[j] = 32'(item_id) >= (j + 1) * bssi_pkg::LAYER_SPAN;
    end
    lay_ins = '0;
    for (int j = 0; j < bssi_pkg::NUM_LAYERS - 1; j++) begin
      if (ge[j] && !ge[j+1]) begin
        lay_ins = lay_ins | bssi_pkg::LAY_W'(j + 1);
      end
    end
  end

  assign range_ok = (item_id >= lowest_id) && (item_id <= highest_id);
  assign rlay_ok  = 32'(item_rlay) < bssi_pkg::NUM_LAYERS;

  // item, decode and lookup registers
  always_ff @(posedge clk) begin
    if (cmd.item_load) begin
      item_kind <= kind;
      item_id   <= module_id;
      item_rlay <= read_layer;
      item_rpos <= read_position;
    end
    if (cmd.decode) begin
      if (!item_kind) begin
        lay_ok <= range_ok && !ge[bssi_pkg::NUM_LAYERS-1];
        lay    <= (range_ok && !ge[bssi_pkg::NUM_LAYERS-1]) ? lay_ins : '0;
      end else begin
        lay_ok <= rlay_ok;
        lay    <= rlay_ok ? bssi_pkg::LAY_W'(item_rlay) : '0;
      end
    end
    if (cmd.lookup) begin
      cnt  <= lay_ok ? counts[lay] : '0;
      base <= bssi_pkg::ADDR_W'(32'(lay) * bssi_pkg::ENTRIES_PER_LAYER);
    end
    if (cmd.write_new) begin
      cnt <= cnt + 1'b1;
    end
  end

  // scan position, insert position and shift pointer
  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      ppos <= '0;
    end else if (cmd.scan_step) begin
      ppos <= ppos + 1'b1;
    end
    if (cmd.pos_clear) begin
      pos <= '0;
      dup <= 1'b0;
    end else if (cmd.scan_end) begin
      pos <= st.hit_ge ? bssi_pkg::CNT_W'(ppos) : cnt;
      dup <= st.hit_ge && st.hit_eq;
    end
    if (cmd.shift_start) begin
      k <= bssi_pkg::OFF_W'(cnt);
    end else if (cmd.shift_step) begin
      k <= k - 1'b1;
    end
    if (cmd.val_load) begin
      val <= rdata;
    end
  end

  // per-layer counts
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < bssi_pkg::NUM_LAYERS; j++) begin
        counts[j] <= '0;
      end
    end else if (cmd.write_new) begin
      counts[lay] <= cnt + 1'b1;
    end
  end

  // status toward the controller
  always_comb begin
    st.kind       = item_kind;
    st.lay_ok     = lay_ok;
    st.cnt_zero   = (cnt == '0);
    st.rd_ok      = (32'(item_rpos) < 32'(cnt)) &&
                    (32'(item_rpos) < bssi_pkg::ENTRIES_PER_LAYER);
    st.hit_ge     = (rdata >= item_id);
    st.hit_eq     = (rdata == item_id);
    st.scan_last  = ((bssi_pkg::CNT_W'(ppos) + 1'b1) == cnt);
    st.dup        = dup;
    st.full       = (32'(cnt) >= bssi_pkg::ENTRIES_PER_LAYER);
    st.pos_at_end = (pos == cnt);
    st.shift_last = (bssi_pkg::CNT_W'(k) == pos + 1'b1);
  end

  // memory read offset
  always_comb begin
    roff = '0;
    if (cmd.scan_step) begin
      roff = st.scan_last ? '0 : ppos + 1'b1;
    end else if (cmd.shift_start) begin
      roff = bssi_pkg::OFF_W'(cnt - 1'b1);
    end else if (cmd.shift_step) begin
      roff = st.shift_last ? '0 : k - 2'd2;
    end else if (cmd.rd_issue) begin
      roff = bssi_pkg::OFF_W'(item_rpos);
    end
  end

  // memory write: move one entry up, or place the new identifier
  always_comb begin
    mem_we = cmd.shift_step || cmd.write_new;
    woff   = cmd.shift_step ? k : bssi_pkg::OFF_W'(pos);
    wdata  = cmd.shift_step ? rdata : item_id;
  end

  assign raddr = base + bssi_pkg::ADDR_W'(roff);
  assign waddr = base + bssi_pkg::ADDR_W'(woff);

  // entry store, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  // result word
  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      status      <= cmd.res_code;
      layer       <= cmd.res_blank ? '0 : bssi_pkg::LAYER_W'(lay);
      layer_count <= cmd.res_blank ? '0 : bssi_pkg::COUNT_W'(cnt);
      entry_value <= (cmd.res_code == bssi_pkg::ST_READ_OK) ? val : '0;
    end
  end

endmodule

[sv/bucketed_sorted_set_insert.sv]
// ----------------------------------------------------------------------------
// bucketed_sorted_set_insert
// Per-layer ascending, duplicate-free lists of module identifiers with
// insert and positional read.
// ----------------------------------------------------------------------------
// The block works on one word at a time and gives one result word for each.
// For an insert, the scan reads the layer list from its start one entry per
// cycle until it meets an entry not below the identifier, then the entries
// above the insert point move up one per cycle through the one read port
// and one write port of the entry memory. The next word is taken once the
// result is in the output register, even while that result still waits to
// be taken. The entry memory is not cleared; only positions below a layer's
// count are read.
// ----------------------------------------------------------------------------
module bucketed_sorted_set_insert (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic                            cfg_index,
  input  logic [bssi_pkg::ID_W-1:0]       cfg_data,
  input  logic                            item_valid,
  output logic                            item_stall,
  input  logic                            kind,
  input  logic [bssi_pkg::ID_W-1:0]       module_id,
  input  logic [bssi_pkg::LAYER_W-1:0]    read_layer,
  input  logic [bssi_pkg::POSITION_W-1:0] read_position,
  output logic                            result_valid,
  input  logic                            result_stall,
  output logic [bssi_pkg::STATUS_W-1:0]   status,
  output logic [bssi_pkg::LAYER_W-1:0]    layer,
  output logic [bssi_pkg::COUNT_W-1:0]    layer_count,
  output logic [bssi_pkg::ID_W-1:0]       entry_value
);

  bssi_pkg::cmd_t cmd;
  bssi_pkg::st_t  st;

  // sequencer
  bssi_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .st           (st),
    .cmd          (cmd)
  );

  // datapath and entry store
  bssi_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .kind          (kind),
    .module_id     (module_id),
    .read_layer    (read_layer),
    .read_position (read_position),
    .cmd           (cmd),
    .st            (st),
    .status        (status),
    .layer         (layer),
    .layer_count   (layer_count),
    .entry_value   (entry_value)
  );

  // busy right after a word is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall |=> item_stall)
    else $error("block idle right after taking a word");

  // a result is only loaded into a free output register
  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.res_load |-> (!result_valid || !result_stall))
    else $error("result loaded over a waiting result");

  // entries move only in a layer with room
  a_shift_has_room: assert property (@(posedge clk) disable iff (rst)
    cmd.shift_step |-> !st.full)
    else $error("shift in a full layer");

  // a new result appears only out of a busy cycle
  a_result_from_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(item_stall))
    else $error("result raised without a word in progress");

endmodule

[tb/sv/bucketed_sorted_set_insert_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bucketed_sorted_set_insert_tb
// Drives insert and read words into the per-layer sorted lists and checks
// every result word against a local copy of the lists kept in step with the
// accepted words. Phases change the accepted identifier range while the
// block is idle; both handshakes idle in random bursts except at the end.
// ----------------------------------------------------------------------------
module bucketed_sorted_set_insert_tb;
  import bssi_pkg::*;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_READ   = 1'b1;
  localparam int   ID_MAX      = (1 << ID_W) - 1;
  localparam int   CYCLE_LIMIT = 400000;

  // one operation on the sets
  typedef struct packed {
    logic                  kind;
    logic [ID_W-1:0]       module_id;
    logic [LAYER_W-1:0]    read_layer;
    logic [POSITION_W-1:0] read_position;
  } set_op_t;

  // one reply from the sets
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [LAYER_W-1:0]  layer;
    logic [COUNT_W-1:0]  count;
    logic [ID_W-1:0]     value;
  } set_reply_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_write = 1'b0;
  logic                  cfg_index = CFG_LOWEST;
  logic [ID_W-1:0]       cfg_data = '0;
  logic                  item_valid = 1'b0;
  logic                  item_stall;
  logic                  kind = KIND_INSERT;
  logic [ID_W-1:0]       module_id = '0;
  logic [LAYER_W-1:0]    read_layer = '0;
  logic [POSITION_W-1:0] read_position = '0;
  logic                  result_valid;
  logic                  result_stall = 1'b0;
  logic [STATUS_W-1:0]   status;
  logic [LAYER_W-1:0]    layer;
  logic [COUNT_W-1:0]    layer_count;
  logic [ID_W-1:0]       entry_value;

  // local copy of the lists and the accepted range
  logic [ID_W-1:0] list_ids [NUM_LAYERS][ENTRIES_PER_LAYER];
  int              list_count [NUM_LAYERS];
  logic [ID_W-1:0] accept_low  = LOWEST_RESET;
  logic [ID_W-1:0] accept_high = HIGHEST_RESET;

  set_op_t    pending_ops [$];
  set_reply_t expected_replies [$];
  bit         queued_ids [int];
  int         queued_list [$];

  set_op_t    next_op;
  set_reply_t got_reply;
  set_reply_t want_reply;
  int         words_issued  = 0;
  int         words_checked = 0;
  int         fail_count    = 0;
  int         gap_left      = 0;
  int         stall_left    = 0;
  int         cycle_count   = 0;
  bit         idling_on     = 1'b1;

  bucketed_sorted_set_insert dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .kind         (kind),
    .module_id    (module_id),
    .read_layer   (read_layer),
    .read_position(read_position),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .status       (status),
    .layer        (layer),
    .layer_count  (layer_count),
    .entry_value  (entry_value)
  );

  always #4 clk = ~clk;

  // apply one accepted word to the local lists and give its reply
  function automatic set_reply_t apply_set_op(input set_op_t op);
    set_reply_t r;
    int lay;
    int cnt;
    int pos;
    r = '0;
    if (op.kind == KIND_INSERT) begin
      lay = int'(op.module_id) / LAYER_SPAN;
      if (op.module_id < accept_low || op.module_id > accept_high || lay >= NUM_LAYERS) begin
        r.status = ST_OUT_RANGE;
      end else begin
        cnt = list_count[lay];
        pos = 0;
        while (pos < cnt && list_ids[lay][pos] < op.module_id) pos++;
        r.layer = LAYER_W'(lay);
        if (pos < cnt && list_ids[lay][pos] == op.module_id) begin
          // duplicates win over a full list
          r.status = ST_PRESENT;
          r.count  = COUNT_W'(cnt);
        end else if (cnt >= ENTRIES_PER_LAYER) begin
          r.status = ST_FULL;
          r.count  = COUNT_W'(cnt);
        end else begin
          for (int k = cnt; k > pos; k--) list_ids[lay][k] = list_ids[lay][k-1];
          list_ids[lay][pos] = op.module_id;
          list_count[lay]    = cnt + 1;
          r.status = ST_INSERTED;
          r.count  = COUNT_W'(cnt + 1);
        end
      end
    end else if (int'(op.read_layer) < NUM_LAYERS) begin
      lay     = int'(op.read_layer);
      cnt     = list_count[lay];
      r.layer = op.read_layer;
      r.count = COUNT_W'(cnt);
      if (int'(op.read_position) < cnt) begin
        r.status = ST_READ_OK;
        r.value  = list_ids[lay][op.read_position];
      end else begin
        r.status = ST_READ_EMPTY;
      end
    end else begin
      // missing layer
      r.status = ST_READ_EMPTY;
    end
    return r;
  endfunction

  // driver: present queued words, hold each until taken
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      gap_left   <= 0;
    end else begin
      if (item_valid && !item_stall) begin
        expected_replies.insert(expected_replies.size(),
                                apply_set_op('{kind, module_id, read_layer, read_position}));
      end
      if (item_valid && item_stall) begin
        // payload held while stalled
      end else if (gap_left > 0) begin
        item_valid <= 1'b0;
        gap_left   <= gap_left - 1;
      end else if (item_valid && idling_on && $urandom_range(0, 3) == 0) begin
        item_valid <= 1'b0;
        gap_left   <= $urandom_range(0, 5);
      end else if (pending_ops.size() != 0) begin
        next_op       = pending_ops.pop_front();
        item_valid    <= 1'b1;
        kind          <= next_op.kind;
        module_id     <= next_op.module_id;
        read_layer    <= next_op.read_layer;
        read_position <= next_op.read_position;
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  // monitor: check each taken result word, stall in bursts
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
      stall_left   <= 0;
    end else begin
      if (result_valid && !result_stall) begin
        got_reply = '{status, layer, layer_count, entry_value};
        if (expected_replies.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result word: status %0d layer %0d count %0d value %0d",
                     status, layer, layer_count, entry_value);
        end else begin
          want_reply = expected_replies.pop_front();
          words_checked++;
          if (got_reply !== want_reply) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch (exp/got): status %0d/%0d layer %0d/%0d count %0d/%0d value %0d/%0d",
                       want_reply.status, got_reply.status, want_reply.layer, got_reply.layer,
                       want_reply.count, got_reply.count, want_reply.value, got_reply.value);
          end
        end
      end
      if (stall_left > 0) begin
        result_stall <= 1'b1;
        stall_left   <= stall_left - 1;
      end else if (idling_on && $urandom_range(0, 7) == 0) begin
        result_stall <= 1'b1;
        stall_left   <= $urandom_range(0, 5);
      end else begin
        result_stall <= 1'b0;
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic push_insert(input int id);
    set_op_t op;
    op = '0;
    op.kind      = KIND_INSERT;
    op.module_id = ID_W'(id);
    pending_ops.insert(pending_ops.size(), op);
    words_issued++;
    queued_ids[id] = 1'b1;
    queued_list.insert(queued_list.size(), id);
  endtask

  task automatic push_read(input int lay, input int pos);
    set_op_t op;
    op = '0;
    op.kind          = KIND_READ;
    op.read_layer    = LAYER_W'(lay);
    op.read_position = POSITION_W'(pos);
    pending_ops.insert(pending_ops.size(), op);
    words_issued++;
  endtask

  // identifier in a layer that has not been sent yet
  function automatic int fresh_in_layer(input int lay);
    int id;
    do begin
      id = lay * LAYER_SPAN + int'($urandom_range(0, LAYER_SPAN - 1));
    end while (id > ID_MAX || queued_ids.exists(id));
    return id;
  endfunction

  // fill one empty layer past its capacity, then hit it with duplicates
  task automatic add_fill(input int lay);
    int taken [$];
    int id;
    for (int i = 0; i < ENTRIES_PER_LAYER + 6; i++) begin
      if ($urandom_range(0, 9) == 0) push_read(lay, $urandom_range(0, ENTRIES_PER_LAYER - 1));
      id = fresh_in_layer(lay);
      taken.insert(taken.size(), id);
      push_insert(id);
    end
    repeat (4) push_insert(taken[$urandom_range(0, ENTRIES_PER_LAYER - 1)]);
    push_read(lay, ENTRIES_PER_LAYER - 1);
  endtask

  // mostly sensible traffic around two layers, some noise
  task automatic add_random(input int n, input int hot_a, input int hot_b);
    int r;
    int sel;
    int lay;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 30) begin
        sel = $urandom_range(0, 2);
        lay = (sel == 0) ? hot_a : (sel == 1) ? hot_b : int'($urandom_range(0, 31));
        push_read(lay, $urandom_range(0, 1) ? $urandom_range(0, ENTRIES_PER_LAYER - 1)
                                            : $urandom_range(0, 7));
      end else if (r < 42 || (r < 60 && queued_list.size() == 0)) begin
        push_insert($urandom_range(0, ID_MAX));
      end else if (r < 60) begin
        push_insert(queued_list[$urandom_range(0, queued_list.size() - 1)]);
      end else begin
        push_insert(fresh_in_layer((r < 80) ? hot_a : hot_b));
      end
    end
  endtask

  task automatic write_reg(input logic idx, input logic [ID_W-1:0] data);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == CFG_LOWEST) accept_low = data;
    else accept_high = data;
  endtask

  task automatic drain_all();
    while (words_checked != words_issued) @(posedge clk);
  endtask

  // stimulus and phases
  initial begin
    for (int l = 0; l < NUM_LAYERS; l++) begin
      list_count[l] = 0;
      for (int e = 0; e < ENTRIES_PER_LAYER; e++) list_ids[l][e] = '0;
    end
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // reset range: edges, sorted placement, reads
    push_read(0, 0);
    push_insert(0);
    push_insert(ID_MAX);
    push_insert(49999);
    push_insert(50000);
    push_insert(221479);
    push_insert(221480);
    push_insert(57000);
    push_insert(53000);
    push_insert(50001);
    push_insert(53000);
    push_read(5, 0);
    push_read(5, 3);
    push_read(5, 4);
    push_read(5, 63);
    push_read(22, 0);
    push_read(23, 0);
    push_read(31, 63);
    push_insert(59999);
    add_fill(12);
    add_random(140, 5, 22);
    drain_all();

    // widest range, layers beyond the last list
    write_reg(CFG_LOWEST, '0);
    write_reg(CFG_HIGHEST, ID_W'(ID_MAX));
    push_insert(230000);
    push_insert(ID_MAX);
    push_insert(0);
    push_insert(229999);
    add_fill(3);
    add_random(140, 0, 22);
    drain_all();

    // single accepted identifier
    write_reg(CFG_LOWEST, 18'd150000);
    write_reg(CFG_HIGHEST, 18'd150000);
    push_insert(149999);
    push_insert(150000);
    push_insert(150001);
    add_random(37, 15, 14);
    drain_all();

    // empty range, lowest above highest
    write_reg(CFG_LOWEST, ID_W'(ID_MAX));
    write_reg(CFG_HIGHEST, '0);
    add_random(40, 12, 3);
    drain_all();

    // last part without idling
    write_reg(CFG_LOWEST, 18'd20000);
    write_reg(CFG_HIGHEST, 18'd99999);
    idling_on = 1'b0;
    add_random(100, 2, 9);
    drain_all();

    repeat (80) @(posedge clk);
    if (fail_count == 0 && expected_replies.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
